/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the resampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SPUR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define SPUR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/spur_pkg.sv */
// ----------------------------------------------------------------------------
// spur_pkg
// Types and constants shared by the uniform resampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spur_pkg;

  localparam int unsigned RegW = 31;
  localparam int unsigned SidW = 16;
  localparam int unsigned AccW = 32;

  localparam logic [RegW-1:0] SpacingRst = 31'd3932;
  localparam logic [RegW-1:0] BreakRst   = 31'd16384;

  typedef enum logic {
    CFG_SPACING = 1'b0,
    CFG_BREAK   = 1'b1
  } spur_cfg_e;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } spur_op_e;

  typedef struct packed {
    logic     start;
    spur_op_e op;
  } spur_req_t;

endpackage

`default_nettype wire

/* sv/scan_point_uniform_resampler_top.sv */
// ----------------------------------------------------------------------------
// scan_point_uniform_resampler_top
// Arc-length resampler for the 2D points of a lidar scan (Q.16 metres).
// ----------------------------------------------------------------------------
// One input point is taken at a time; in_ready_o is low while it is worked on.
// Multiplies, divides and square roots run through one bit-serial unit of
// width DW, the larger of 64 and COORD_BITS+33 rounded up to even (66 at the
// default width). The first point of a scan is passed on as is. Each segment
// length is the root of the summed squares of the deltas after a right shift
// by k (k = right shift needed to bring the larger coordinate delta under
// 2^31, zero for short segments), shifted back left by k; each interpolated
// point takes a multiply and a rounded divide per axis. Results leave
// through a one-deep output register plus one pending word, so a stalled
// output stalls the sequencer.
`default_nettype none

module scan_point_uniform_resampler_top #(
  parameter int unsigned MAX_RUN    = 16,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [spur_pkg::RegW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [spur_pkg::SidW-1:0]     source_id_i,
  input  wire logic signed [COORD_BITS-1:0]  x_i,
  input  wire logic signed [COORD_BITS-1:0]  y_i,
  input  wire logic                          first_point_i,
  input  wire logic                          last_point_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [spur_pkg::SidW-1:0]          out_source_id_o,
  output logic signed [COORD_BITS-1:0]       out_x_o,
  output logic signed [COORD_BITS-1:0]       out_y_o,
  output logic                               point_valid_o,
  output logic                               run_last_o,
  output logic                               scan_end_o
);

  `include "assert_macros.svh"

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned MW  = CB + 1;
  localparam int unsigned LW  = (CB + 2 > 32) ? CB + 2 : 32;
  localparam int unsigned SW  = LW + 1;
  localparam int unsigned DW0 = (CB + 33 > 64) ? CB + 33 : 64;
  localparam int unsigned DW  = DW0 + (DW0 % 2);
  localparam int unsigned RW  = $clog2(MAX_RUN + 1);
  localparam int unsigned KW  = $clog2(MW);
  localparam int unsigned RgW = spur_pkg::RegW;
  localparam int unsigned AW  = spur_pkg::AccW;
  localparam int unsigned IdW = spur_pkg::SidW;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_ITER   = 15'b000000000000010,
    S_NORM   = 15'b000000000000100,
    S_SQA    = 15'b000000000001000,
    S_SQB    = 15'b000000000010000,
    S_ROOT   = 15'b000000000100000,
    S_SHIFT  = 15'b000000001000000,
    S_DECIDE = 15'b000000010000000,
    S_MULX   = 15'b000000100000000,
    S_DIVX   = 15'b000001000000000,
    S_MULY   = 15'b000010000000000,
    S_DIVY   = 15'b000100000000000,
    S_BUILD  = 15'b001000000000000,
    S_PUSH   = 15'b010000000000000,
    S_FLUSH  = 15'b100000000000000
  } state_e;

  state_e          state_q, state_d;
  logic [RgW-1:0]  spacing_q, spacing_d;
  logic [RgW-1:0]  break_q, break_d;
  logic [CB-1:0]   prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [AW-1:0]   acc_q, acc_d;
  logic            have_prev_q, have_prev_d;
  logic [RW-1:0]   n_q, n_d;
  logic            pend_valid_q, pend_valid_d;
  logic            out_valid_q, out_valid_d;

  logic [IdW-1:0]  sid_q, sid_d;
  logic [CB-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic            last_q, last_d;
  logic [KW-1:0]   k_q, k_d;
  logic [MW-1:0]   na_q, na_d, nb_q, nb_d;
  logic [MW-1:0]   adx_q, adx_d, ady_q, ady_d;
  logic            sx_q, sx_d, sy_q, sy_d;
  logic [DW-1:0]   sqa_q, sqa_d;
  logic [LW-1:0]   len_q, len_d;
  logic [RgW-1:0]  num_q, num_d;
  logic [CB-1:0]   qx_q, qx_d, qy_q, qy_d;
  logic [CB-1:0]   nr_x_q, nr_x_d, nr_y_q, nr_y_d;
  logic            fin_q, fin_d;
  logic [IdW-1:0]  pend_sid_q, pend_sid_d;
  logic [CB-1:0]   pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic            pend_pv_q, pend_pv_d;
  logic [IdW-1:0]  out_sid_q, out_sid_d;
  logic [CB-1:0]   out_x_q, out_x_d, out_y_q, out_y_d;
  logic            out_pv_q, out_pv_d, out_rl_q, out_rl_d, out_se_q, out_se_d;

  spur_pkg::spur_req_t alu_req;
  logic [DW-1:0]       alu_opa, alu_opb;
  logic                alu_done;
  logic [DW-1:0]       alu_res;

  logic [MW-1:0]  dx, dy;
  logic [SW-1:0]  sum;
  logic [RgW-1:0] num;
  logic           slot_free;
  logic           in_acc;
  logic           cap;

  spur_alu #(
    .DW (DW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (alu_opa),
    .opb_i  (alu_opb),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    dx        = {cx_q[CB-1], cx_q} - {prev_x_q[CB-1], prev_x_q};
    dy        = {cy_q[CB-1], cy_q} - {prev_y_q[CB-1], prev_y_q};
    sum       = SW'(acc_q) + SW'(len_q);
    num       = (acc_q > AW'(spacing_q)) ? '0 : spacing_q - acc_q[RgW-1:0];
    slot_free = !out_valid_q || out_ready_i;
    in_acc    = in_valid_i && (state_q == S_IDLE);
    cap       = (n_q == RW'(MAX_RUN - 1));
  end

  always_comb begin
    state_d      = state_q;
    spacing_d    = spacing_q;
    break_d      = break_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    acc_d        = acc_q;
    have_prev_d  = have_prev_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    sid_d        = sid_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    last_d       = last_q;
    k_d          = k_q;
    na_d         = na_q;
    nb_d         = nb_q;
    adx_d        = adx_q;
    ady_d        = ady_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    sqa_d        = sqa_q;
    len_d        = len_q;
    num_d        = num_q;
    qx_d         = qx_q;
    qy_d         = qy_q;
    nr_x_d       = nr_x_q;
    nr_y_d       = nr_y_q;
    fin_d        = fin_q;
    pend_sid_d   = pend_sid_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    pend_pv_d    = pend_pv_q;
    out_sid_d    = out_sid_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_pv_d     = out_pv_q;
    out_rl_d     = out_rl_q;
    out_se_d     = out_se_q;
    alu_req.start = 1'b0;
    alu_req.op    = spur_pkg::OP_MUL;
    alu_opa       = '0;
    alu_opb       = '0;

    if (cfg_we_i) begin
      case (spur_pkg::spur_cfg_e'(cfg_idx_i))
        spur_pkg::CFG_SPACING: spacing_d = cfg_data_i;
        spur_pkg::CFG_BREAK:   break_d   = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sid_d  = source_id_i;
          cx_d   = x_i;
          cy_d   = y_i;
          last_d = last_point_i;
          n_d    = '0;
          if (first_point_i || !have_prev_q) begin
            // scan start: keep the point as is
            pend_valid_d = 1'b1;
            pend_sid_d   = source_id_i;
            pend_x_d     = x_i;
            pend_y_d     = y_i;
            pend_pv_d    = 1'b1;
            prev_x_d     = x_i;
            prev_y_d     = y_i;
            acc_d        = '0;
            have_prev_d  = 1'b1;
            state_d      = S_FLUSH;
          end else begin
            state_d = S_ITER;
          end
        end
      end
      S_ITER: begin
        sx_d    = dx[MW-1];
        sy_d    = dy[MW-1];
        adx_d   = dx[MW-1] ? -dx : dx;
        ady_d   = dy[MW-1] ? -dy : dy;
        na_d    = dx[MW-1] ? -dx : dx;
        nb_d    = dy[MW-1] ? -dy : dy;
        k_d     = '0;
        state_d = S_NORM;
      end
      S_NORM: begin
        // scale down until both deltas fit 31 bits
        if (((na_q >> 31) != '0) || ((nb_q >> 31) != '0)) begin
          na_d = na_q >> 1;
          nb_d = nb_q >> 1;
          k_d  = k_q + KW'(1);
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = spur_pkg::OP_MUL;
          alu_opa       = DW'(na_q);
          alu_opb       = DW'(na_q);
          state_d       = S_SQA;
        end
      end
      S_SQA: begin
        if (alu_done) begin
          sqa_d         = alu_res;
          alu_req.start = 1'b1;
          alu_req.op    = spur_pkg::OP_MUL;
          alu_opa       = DW'(nb_q);
          alu_opb       = DW'(nb_q);
          state_d       = S_SQB;
        end
      end
      S_SQB: begin
        if (alu_done) begin
          alu_req.start = 1'b1;
          alu_req.op    = spur_pkg::OP_SQRT;
          alu_opa       = sqa_q + alu_res;
          state_d       = S_ROOT;
        end
      end
      S_ROOT: begin
        if (alu_done) begin
          len_d   = alu_res[LW-1:0];
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // undo the scaling on the root
        if (k_q != '0) begin
          len_d = {len_q[LW-2:0], 1'b0};
          k_d   = k_q - KW'(1);
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sum < SW'(spacing_q)) begin
          acc_d    = (sum[SW-1:AW] != '0) ? '1 : sum[AW-1:0];
          prev_x_d = cx_q;
          prev_y_d = cy_q;
          state_d  = S_FLUSH;
        end else if (sum >= SW'(break_q)) begin
          nr_x_d   = cx_q;
          nr_y_d   = cy_q;
          prev_x_d = cx_q;
          prev_y_d = cy_q;
          acc_d    = '0;
          n_d      = n_q + RW'(1);
          fin_d    = 1'b1;
          state_d  = S_PUSH;
        end else if (len_q == '0) begin
          qx_d    = '0;
          qy_d    = '0;
          state_d = S_BUILD;
        end else begin
          num_d         = num;
          alu_req.start = 1'b1;
          alu_req.op    = spur_pkg::OP_MUL;
          alu_opa       = DW'(adx_q);
          alu_opb       = DW'(num);
          state_d       = S_MULX;
        end
      end
      S_MULX: begin
        if (alu_done) begin
          alu_req.start = 1'b1;
          alu_req.op    = spur_pkg::OP_DIV;
          alu_opa       = alu_res + DW'(len_q >> 1);
          alu_opb       = DW'(len_q);
          state_d       = S_DIVX;
        end
      end
      S_DIVX: begin
        if (alu_done) begin
          qx_d          = alu_res[CB-1:0];
          alu_req.start = 1'b1;
          alu_req.op    = spur_pkg::OP_MUL;
          alu_opa       = DW'(ady_q);
          alu_opb       = DW'(num_q);
          state_d       = S_MULY;
        end
      end
      S_MULY: begin
        if (alu_done) begin
          alu_req.start = 1'b1;
          alu_req.op    = spur_pkg::OP_DIV;
          alu_opa       = alu_res + DW'(len_q >> 1);
          alu_opb       = DW'(len_q);
          state_d       = S_DIVY;
        end
      end
      S_DIVY: begin
        if (alu_done) begin
          qy_d    = alu_res[CB-1:0];
          state_d = S_BUILD;
        end
      end
      S_BUILD: begin
        nr_x_d = sx_q ? prev_x_q - qx_q : prev_x_q + qx_q;
        nr_y_d = sy_q ? prev_y_q - qy_q : prev_y_q + qy_q;
        acc_d  = '0;
        n_d    = n_q + RW'(1);
        fin_d  = cap;
        if (cap) begin
          // run cap reached: skip the rest of the segment
          prev_x_d = cx_q;
          prev_y_d = cy_q;
        end else begin
          prev_x_d = sx_q ? prev_x_q - qx_q : prev_x_q + qx_q;
          prev_y_d = sy_q ? prev_y_q - qy_q : prev_y_q + qy_q;
        end
        state_d = S_PUSH;
      end
      S_PUSH: begin
        // hold the newest word back until it is known whether it ends the run
        if (!pend_valid_q || slot_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_sid_d   = pend_sid_q;
            out_x_d     = pend_x_q;
            out_y_d     = pend_y_q;
            out_pv_d    = pend_pv_q;
            out_rl_d    = 1'b0;
            out_se_d    = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_sid_d   = sid_q;
          pend_x_d     = nr_x_q;
          pend_y_d     = nr_y_q;
          pend_pv_d    = 1'b1;
          state_d      = fin_q ? S_FLUSH : S_ITER;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q && !last_q) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          out_valid_d  = 1'b1;
          out_sid_d    = pend_valid_q ? pend_sid_q : sid_q;
          out_x_d      = pend_valid_q ? pend_x_q : '0;
          out_y_d      = pend_valid_q ? pend_y_q : '0;
          out_pv_d     = pend_valid_q && pend_pv_q;
          out_rl_d     = 1'b1;
          out_se_d     = last_q;
          pend_valid_d = 1'b0;
          if (last_q) begin
            have_prev_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      spacing_q    <= spur_pkg::SpacingRst;
      break_q      <= spur_pkg::BreakRst;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      acc_q        <= '0;
      have_prev_q  <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      spacing_q    <= spacing_d;
      break_q      <= break_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      acc_q        <= acc_d;
      have_prev_q  <= have_prev_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sid_q      <= sid_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    last_q     <= last_d;
    k_q        <= k_d;
    na_q       <= na_d;
    nb_q       <= nb_d;
    adx_q      <= adx_d;
    ady_q      <= ady_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sqa_q      <= sqa_d;
    len_q      <= len_d;
    num_q      <= num_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    nr_x_q     <= nr_x_d;
    nr_y_q     <= nr_y_d;
    fin_q      <= fin_d;
    pend_sid_q <= pend_sid_d;
    pend_x_q   <= pend_x_d;
    pend_y_q   <= pend_y_d;
    pend_pv_q  <= pend_pv_d;
    out_sid_q  <= out_sid_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_pv_q   <= out_pv_d;
    out_rl_q   <= out_rl_d;
    out_se_q   <= out_se_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_source_id_o = out_sid_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign point_valid_o   = out_pv_q;
  assign run_last_o      = out_rl_q;
  assign scan_end_o      = out_se_q;

  `SPUR_ASSERT(a_idle_no_pend, in_ready_o |-> !pend_valid_q, "pending word left at idle")
  `SPUR_ASSERT(a_run_bound, n_q <= RW'(MAX_RUN), "run count beyond cap")
  `SPUR_ASSERT(a_prev_clear, $fell(have_prev_q) |-> $past(last_q), "scan closed without last point")

endmodule

`default_nettype wire

/* sv/spur_alu.sv */
// ----------------------------------------------------------------------------
// spur_alu
// Bit-serial shared unit: shift-add multiply, restoring divide, integer root.
// ----------------------------------------------------------------------------
`default_nettype none

module spur_alu #(
  parameter int unsigned DW = 66
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spur_pkg::spur_req_t req_i,
  input  wire logic [DW-1:0]      opa_i,
  input  wire logic [DW-1:0]      opb_i,
  output logic                    done_o,
  output logic [DW-1:0]           res_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  spur_pkg::spur_op_e op_q, op_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     a_q, a_d;
  logic [DW-1:0]     sh_q, sh_d;
  logic [DW-1:0]     res_q, res_d;
  logic [DW:0]       rem_q, rem_d;

  logic          is_div;
  logic [DW:0]   trial_t;
  logic [DW:0]   sub_b;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] mul_sum;

  always_comb begin
    is_div  = (op_q == spur_pkg::OP_DIV);
    trial_t = is_div ? {rem_q[DW-1:0], sh_q[DW-1]} : {rem_q[DW-2:0], sh_q[DW-1:DW-2]};
    sub_b   = is_div ? {1'b0, a_q} : {res_q[DW-2:0], 2'b01};
    ge      = (trial_t >= sub_b);
    diff    = trial_t - sub_b;
    mul_sum = {res_q[DW-2:0], 1'b0} + (sh_q[DW-1] ? a_q : '0);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    sh_d   = sh_q;
    res_d  = res_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = (req_i.op == spur_pkg::OP_SQRT) ? CW'(DW / 2) : CW'(DW);
      a_d    = (req_i.op == spur_pkg::OP_DIV) ? opb_i : opa_i;
      sh_d   = (req_i.op == spur_pkg::OP_MUL) ? opb_i : opa_i;
      res_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      case (op_q)
        spur_pkg::OP_MUL: begin
          res_d = mul_sum;
          sh_d  = {sh_q[DW-2:0], 1'b0};
        end
        spur_pkg::OP_DIV: begin
          rem_d = ge ? diff : trial_t;
          res_d = {res_q[DW-2:0], ge};
          sh_d  = {sh_q[DW-2:0], 1'b0};
        end
        default: begin
          rem_d = ge ? diff : trial_t;
          res_d = {res_q[DW-2:0], ge};
          sh_d  = {sh_q[DW-3:0], 2'b00};
        end
      endcase
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= spur_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    sh_q  <= sh_d;
    res_q <= res_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* dv/tb_scan_point_uniform_resampler_top.sv */
// ----------------------------------------------------------------------------
// tb_scan_point_uniform_resampler_top
// Self-checking bench for the scan point uniform resampler.
// ----------------------------------------------------------------------------
// Points are sent through the input handshake and every accepted point runs
// through a resampling predictor of the same fixed-point arithmetic. Emitted
// words are compared field by field, in order, against the predicted words.
// Directed scans cover the special cases; random scans follow, with random
// gaps on both sides, register changes while idle and a final stretch at
// full rate.
// ----------------------------------------------------------------------------

module tb_scan_point_uniform_resampler_top;

  localparam int unsigned MaxRun     = 16;
  localparam int unsigned CoordBits  = 32;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCyc  = 1000;
  localparam logic [spur_pkg::RegW-1:0] RegMax = 31'h7fff_ffff;

  typedef struct packed {
    logic [spur_pkg::SidW-1:0] sid;
    logic [CoordBits-1:0]      x;
    logic [CoordBits-1:0]      y;
    logic                      pv;
    logic                      rl;
    logic                      se;
  } point_word_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic                        cfg_idx_i;
  logic [spur_pkg::RegW-1:0]   cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [spur_pkg::SidW-1:0]   source_id_i;
  logic signed [CoordBits-1:0] x_i;
  logic signed [CoordBits-1:0] y_i;
  logic                        first_point_i;
  logic                        last_point_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [spur_pkg::SidW-1:0]   out_source_id_o;
  logic signed [CoordBits-1:0] out_x_o;
  logic signed [CoordBits-1:0] out_y_o;
  logic                        point_valid_o;
  logic                        run_last_o;
  logic                        scan_end_o;

  scan_point_uniform_resampler_top #(
    .MAX_RUN   (MaxRun),
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .source_id_i    (source_id_i),
    .x_i            (x_i),
    .y_i            (y_i),
    .first_point_i  (first_point_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_source_id_o(out_source_id_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .point_valid_o  (point_valid_o),
    .run_last_o     (run_last_o),
    .scan_end_o     (scan_end_o)
  );

  // Predictor state
  logic [spur_pkg::RegW-1:0] spacing_q;
  logic [spur_pkg::RegW-1:0] break_q;
  longint          prev_x;
  longint          prev_y;
  logic [31:0]     acc_dist;
  bit              have_prev;

  point_word_t pending_points[$];
  int          errors;
  bit          idle_en;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root64(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] seg_length(logic [63:0] a, logic [63:0] b);
    int          k;
    logic [63:0] m;
    k = 0;
    m = (a > b) ? a : b;
    while ((m >> 31) != 0) begin
      m = m >> 1;
      a = a >> 1;
      b = b >> 1;
      k++;
    end
    return root64(a * a + b * b) << k;
  endfunction

  function automatic logic [63:0] scaled_offset(logic [63:0] d, logic [63:0] num,
                                                logic [63:0] len);
    logic [127:0] p;
    p = {64'd0, d} * {64'd0, num} + {64'd0, len >> 1};
    p = p / {64'd0, len};
    return p[63:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Work out every word one point emits and queue them.
  task automatic resample_point(logic [spur_pkg::SidW-1:0] sid,
                                logic signed [CoordBits-1:0] x,
                                logic signed [CoordBits-1:0] y, logic fp, logic lp);
    point_word_t run[$];
    point_word_t w;
    longint      cx;
    longint      cy;
    longint      dx;
    longint      dy;
    longint      nx;
    longint      ny;
    logic [63:0] len;
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] qx;
    logic [63:0] qy;
    cx = x;
    cy = y;
    w = '0;
    w.sid = sid;
    w.pv = 1'b1;
    if (fp || !have_prev) begin
      w.x = x;
      w.y = y;
      run = {run, w};
      prev_x = cx;
      prev_y = cy;
      acc_dist = '0;
      have_prev = 1'b1;
    end else begin
      while (run.size() < MaxRun) begin
        dx = cx - prev_x;
        dy = cy - prev_y;
        len = seg_length(magnitude(dx), magnitude(dy));
        sum = {32'd0, acc_dist} + len;
        if (sum < {33'd0, spacing_q}) begin
          acc_dist = (sum > 64'hffff_ffff) ? 32'hffff_ffff : sum[31:0];
          prev_x = cx;
          prev_y = cy;
          break;
        end
        if (sum >= {33'd0, break_q}) begin
          w.x = x;
          w.y = y;
          run = {run, w};
          prev_x = cx;
          prev_y = cy;
          acc_dist = '0;
          break;
        end
        // Clamp when spacing was lowered under the running distance.
        num = (acc_dist > {1'b0, spacing_q}) ? 64'd0 : 64'(spacing_q) - 64'(acc_dist);
        if (len == 0) begin
          qx = '0;
          qy = '0;
        end else begin
          qx = scaled_offset(magnitude(dx), num, len);
          qy = scaled_offset(magnitude(dy), num, len);
        end
        nx = (dx < 0) ? prev_x - longint'(qx) : prev_x + longint'(qx);
        ny = (dy < 0) ? prev_y - longint'(qy) : prev_y + longint'(qy);
        w.x = nx[CoordBits-1:0];
        w.y = ny[CoordBits-1:0];
        run = {run, w};
        prev_x = nx;
        prev_y = ny;
        acc_dist = '0;
        if (run.size() >= MaxRun) begin
          prev_x = cx;
          prev_y = cy;
        end
      end
    end
    if (lp) begin
      if (run.size() == 0) begin
        w = '0;
        w.sid = sid;
        run = {run, w};
      end
      run[run.size()-1].se = 1'b1;
      have_prev = 1'b0;
    end
    if (run.size() > 0) run[run.size()-1].rl = 1'b1;
    foreach (run[i]) pending_points = {pending_points, run[i]};
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // Check each emitted word against the oldest predicted word.
  always @(posedge clk_i) begin
    point_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_x_o), 64'd0);
      end else begin
        w = pending_points.pop_front();
        if (out_source_id_o !== w.sid) report_mismatch("source_id", out_source_id_o, w.sid);
        if (out_x_o !== w.x) report_mismatch("x", out_x_o, w.x);
        if (out_y_o !== w.y) report_mismatch("y", out_y_o, w.y);
        if (point_valid_o !== w.pv) report_mismatch("point_valid", point_valid_o, w.pv);
        if (run_last_o !== w.rl) report_mismatch("run_last", run_last_o, w.rl);
        if (scan_end_o !== w.se) report_mismatch("scan_end", scan_end_o, w.se);
      end
    end
  end

  // Receiver: random ready bursts and stall bursts, always ready once idle_en is low.
  initial begin
    int hold;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!idle_en) begin
        out_ready_i <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_ready_i <= ($urandom_range(0, 9) < 6);
        hold = $urandom_range(1, 15) - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(logic [spur_pkg::SidW-1:0] sid, logic [31:0] x, logic [31:0] y,
                            logic fp, logic lp);
    if (idle_en && $urandom_range(0, 9) < 3) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    source_id_i   <= sid;
    x_i           <= x;
    y_i           <= y;
    first_point_i <= fp;
    last_point_i  <= lp;
    do @(posedge clk_i); while (!in_ready_o);
    resample_point(sid, x, y, fp, lp);
  endtask

  // Hold off until every predicted word is out and the block has settled.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    wait (pending_points.size() == 0);
    @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(spur_pkg::spur_cfg_e idx, logic [spur_pkg::RegW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == spur_pkg::CFG_SPACING) spacing_q = val;
    else break_q = val;
  endtask

  task automatic set_regs(logic [spur_pkg::RegW-1:0] sp, logic [spur_pkg::RegW-1:0] br);
    drain_block();
    write_reg(spur_pkg::CFG_SPACING, sp);
    write_reg(spur_pkg::CFG_BREAK, br);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_scan_edges();
    // Missing first point after reset, then extremes of every field.
    send_point(16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
    send_point(16'hffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0);
    send_point(16'hffff, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
    send_point(16'h5a5a, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1);
    send_point(16'ha5a5, 32'hffff_ffff, 32'h0000_0001, 1'b1, 1'b1);
    // New scan in the middle of one, then a default-spacing run.
    send_point(16'h0001, 32'd0, 32'd0, 1'b1, 1'b0);
    send_point(16'h0002, 32'd10000, 32'd0, 1'b0, 1'b0);
    send_point(16'h0003, 32'd500, 32'd500, 1'b1, 1'b0);
    send_point(16'h0004, 32'd1000, -32'sd2000, 1'b0, 1'b0);
    // Dropped last point gives an end marker only.
    send_point(16'h0005, 32'd1010, -32'sd2000, 1'b0, 1'b1);
  endtask

  task automatic test_run_cap();
    set_regs(31'd1, RegMax);
    send_point(16'h0010, 32'd0, 32'd0, 1'b1, 1'b0);
    send_point(16'h0011, 32'd100, -32'sd37, 1'b0, 1'b0);
    send_point(16'h0012, 32'd130, -32'sd37, 1'b0, 1'b1);
  endtask

  task automatic test_spacing_lowered();
    set_regs(31'd3932, 31'd16384);
    send_point(16'h0020, 32'd0, 32'd0, 1'b1, 1'b0);
    send_point(16'h0021, 32'd3000, 32'd0, 1'b0, 1'b0);
    // Sender waits for every predicted word before the register change.
    set_regs(31'd1000, 31'd16384);
    send_point(16'h0022, 32'd3000, 32'd0, 1'b0, 1'b0);
    send_point(16'h0023, 32'd3100, 32'd40, 1'b0, 1'b0);
    send_point(16'h0024, 32'd3100, 32'd40, 1'b0, 1'b1);
  endtask

  task automatic test_random_scans(int n_items, logic [spur_pkg::RegW-1:0] sp,
                                   logic [spur_pkg::RegW-1:0] br);
    int     sent;
    int     len;
    int     step_max;
    longint px;
    longint py;
    set_regs(sp, br);
    sent = 0;
    step_max = (sp > 31'd1048576) ? 4194304 : 4 * int'(sp) + 4;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any coordinates, any flags.
        send_point(16'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = $urandom_range(2, 12);
        px = $signed(32'($urandom)) >>> $urandom_range(8, 12);
        py = $signed(32'($urandom)) >>> $urandom_range(8, 12);
        for (int i = 0; i < len; i++) begin
          if (i > 0) begin
            px += $urandom_range(0, step_max) - step_max / 2;
            py += $urandom_range(0, step_max) - step_max / 2;
          end
          send_point(16'($urandom), px[31:0], py[31:0], i == 0,
                     (i == len - 1) && ($urandom_range(0, 7) != 0));
          sent++;
        end
      end
    end
  endtask

  initial begin
    errors       = 0;
    idle_en      = 1'b1;
    spacing_q    = spur_pkg::SpacingRst;
    break_q      = spur_pkg::BreakRst;
    prev_x       = 0;
    prev_y       = 0;
    acc_dist     = '0;
    have_prev    = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= spur_pkg::CFG_SPACING;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    source_id_i   <= '0;
    x_i           <= '0;
    y_i           <= '0;
    first_point_i <= 1'b0;
    last_point_i  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_scan_edges();
    test_run_cap();
    test_spacing_lowered();
    test_random_scans(120, 31'd3932, 31'd16384);
    test_random_scans(80, 31'd1000, RegMax);
    test_random_scans(40, RegMax, RegMax);
    test_random_scans(30, 31'd1, 31'd200);
    test_random_scans(80, 31'd20000, 31'd50000);
    drain_block();
    idle_en = 1'b0;
    test_random_scans(80, 31'd3932, 31'd16384);

    drain_block();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/spur_pkg.sv
sv/spur_alu.sv
sv/scan_point_uniform_resampler_top.sv
dv/tb_scan_point_uniform_resampler_top.sv
